FILE: sv/led_strip_pattern_engine_macros.svh
// ----------------------------------------------------------------------------
// LED strip pattern engine assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LED_STRIP_PATTERN_ENGINE_MACROS_SVH
`define LED_STRIP_PATTERN_ENGINE_MACROS_SVH

// The consequent must hold in the cycle after the antecedent.
`define LSP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

// The consequent must hold in the same cycle as the antecedent.
`define LSP_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

`endif

FILE: sv/lsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern engine package
// Mode codes, register indexes, the frame request type and the breathing
// brightness table.
// ----------------------------------------------------------------------------
package lsp_pkg;

	localparam logic [2:0] MODE_SOLID   = 3'd0;
	localparam logic [2:0] MODE_RAINBOW = 3'd1;
	localparam logic [2:0] MODE_BREATHE = 3'd2;
	localparam logic [2:0] MODE_CHASE   = 3'd3;
	localparam logic [2:0] MODE_SCANNER = 3'd4;
	localparam logic [2:0] MODE_TWINKLE = 3'd5;
	localparam logic [2:0] MODE_SPARKLE = 3'd6;
	localparam logic [2:0] MODE_UNUSED  = 3'd7;

	localparam logic [2:0] REG_MODE       = 3'd0;
	localparam logic [2:0] REG_RED        = 3'd1;
	localparam logic [2:0] REG_GREEN      = 3'd2;
	localparam logic [2:0] REG_BLUE       = 3'd3;
	localparam logic [2:0] REG_BRIGHTNESS = 3'd4;

	localparam int LIT_W = 6;

	localparam logic [31:0] LFSR_SEED = 32'hACE1ACE1;
	localparam logic [31:0] LFSR_TAPS = 32'h80200003;

	localparam logic [11:0] BREATHE_PERIOD = 12'd4000;
	localparam logic [17:0] BREATHE_RECIP  = 18'd134218;

	typedef struct packed {
		logic [2:0]       mode;
		logic [7:0]       level;
		logic [7:0]       step;
		logic [1:0]       chase_off;
		logic [LIT_W-1:0] lit;
	} frame_t;

	typedef logic [7:0] breathe_lut_t [0:255];

	function automatic logic [6:0] frame_interval(input logic [2:0] mode);
		logic [6:0] iv;
		case (mode)
			MODE_RAINBOW: iv = 7'd20;
			MODE_BREATHE: iv = 7'd15;
			MODE_CHASE:   iv = 7'd50;
			MODE_SCANNER: iv = 7'd50;
			MODE_TWINKLE: iv = 7'd100;
			MODE_SPARKLE: iv = 7'd30;
			default:      iv = 7'd0;
		endcase
		return iv;
	endfunction

	function automatic longint q30_mul(input longint a, input longint b);
		return a * b / 64'sd1073741824;
	endfunction

	function automatic longint sine_q30(input int m);
		longint x;
		longint sum;
		longint term;
		x = longint'(m) * 64'sd26353589;
		sum = x;
		term = (-q30_mul(q30_mul(x, x), x)) / 64'sd6;
		sum = sum + term;
		term = (-q30_mul(q30_mul(term, x), x)) / 64'sd20;
		sum = sum + term;
		term = (-q30_mul(q30_mul(term, x), x)) / 64'sd42;
		sum = sum + term;
		term = (-q30_mul(q30_mul(term, x), x)) / 64'sd72;
		sum = sum + term;
		term = (-q30_mul(q30_mul(term, x), x)) / 64'sd110;
		sum = sum + term;
		term = (-q30_mul(q30_mul(term, x), x)) / 64'sd156;
		sum = sum + term;
		term = (-q30_mul(q30_mul(term, x), x)) / 64'sd210;
		sum = sum + term;
		return sum;
	endfunction

	function automatic logic [7:0] breathe_entry(input int k);
		int r;
		int m;
		longint s;
		longint sum;
		longint term;
		longint val;
		r = k % 128;
		m = (r <= 64) ? r : 128 - r;
		s = sine_q30(m);
		if (k >= 128) begin
			s = -s;
		end
		sum = 64'sd1073741824;
		term = 64'sd1073741824;
		term = q30_mul(term, s);
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd2;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd3;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd4;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd5;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd6;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd7;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd8;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd9;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd10;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd11;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd12;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd13;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd14;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd15;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd16;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd17;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd18;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd19;
		sum = sum + term;
		term = q30_mul(term, s) / 64'sd20;
		sum = sum + term;
		val = (sum - 64'sd395007542) * 64'sd108;
		if (val <= 0) begin
			return 8'd0;
		end
		val = val / 64'sd1073741824;
		if (val > 255) begin
			return 8'd255;
		end
		return val[7:0];
	endfunction

	function automatic breathe_lut_t build_breathe_lut();
		breathe_lut_t t;
		int k;
		for (k = 0; k < 256; k++) begin
			t[k] = breathe_entry(k);
		end
		return t;
	endfunction

	localparam breathe_lut_t BREATHE_LUT = build_breathe_lut();

endpackage

FILE: sv/lsp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern engine front end
// Takes time requests, tracks elapsed time, breathing phase and pattern step,
// and issues a frame request whenever an animated mode's interval has passed.
// ----------------------------------------------------------------------------
module lsp_front #(
	parameter int PIXEL_COUNT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    ms_elapsed,
	input  logic [2:0]    pattern_mode,
	input  logic [7:0]    base_brightness,
	output logic          push_valid,
	input  logic          push_ready,
	output lsp_pkg::frame_t push_data
);
	import lsp_pkg::*;

	localparam int SW = $clog2(2 * PIXEL_COUNT);

	logic [31:0]      delta_q;
	logic [11:0]      phase_q;
	logic [15:0]      step_q;
	logic [1:0]       step_m3_q;
	logic [SW-1:0]    step_scan_q;

	logic             accept;
	logic [31:0]      delta_new;
	logic             fire;
	logic [12:0]      phase_sum;
	logic [11:0]      phase_new;
	logic             step_inc;
	logic [15:0]      step_new;
	logic [SW-1:0]    scan_pos;

	logic             valid_s1;
	logic [2:0]       mode_s1;
	logic [7:0]       bright_s1;
	logic [7:0]       step_s1;
	logic [1:0]       off_s1;
	logic [LIT_W-1:0] lit_s1;
	logic [11:0]      phase_s1;

	logic             valid_s2;
	logic [2:0]       mode_s2;
	logic [7:0]       bright_s2;
	logic [7:0]       step_s2;
	logic [1:0]       off_s2;
	logic [LIT_W-1:0] lit_s2;
	logic [7:0]       bidx_s2;

	logic             move_s1;
	logic             move_s2;
	logic [32:0]      bprod;

	assign move_s2  = !valid_s2 || push_ready;
	assign move_s1  = !valid_s1 || move_s2;
	assign in_ready = move_s1;
	assign accept   = in_valid && in_ready;

	assign delta_new = delta_q + 32'(ms_elapsed);
	assign fire      = (pattern_mode != MODE_SOLID) && (pattern_mode != MODE_UNUSED) &&
	                   (delta_new > 32'(frame_interval(pattern_mode)));

	assign phase_sum = 13'(phase_q) + 13'(ms_elapsed);
	assign phase_new = (phase_sum >= 13'(BREATHE_PERIOD)) ?
	                   12'(phase_sum - 13'(BREATHE_PERIOD)) : phase_sum[11:0];

	assign step_inc = fire && ((pattern_mode == MODE_RAINBOW) ||
	                           (pattern_mode == MODE_CHASE) || (pattern_mode == MODE_SCANNER));

	always_comb begin
		step_new = step_q + 16'd1;
		if ((pattern_mode == MODE_RAINBOW) && (step_new >= 16'd256)) begin
			step_new = 16'd0;
		end
	end

	assign scan_pos = (step_scan_q < SW'(PIXEL_COUNT)) ? step_scan_q :
	                  SW'(2 * PIXEL_COUNT - 1) - step_scan_q;

	assign bprod = 33'({phase_s1, 3'b000}) * 33'(BREATHE_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delta_q     <= '0;
			phase_q     <= '0;
			step_q      <= '0;
			step_m3_q   <= '0;
			step_scan_q <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (accept) begin
				delta_q <= fire ? 32'd0 : delta_new;
				phase_q <= phase_new;
				if (step_inc) begin
					step_q <= step_new;
					if (step_new == 16'd0) begin
						step_m3_q   <= '0;
						step_scan_q <= '0;
					end else begin
						step_m3_q   <= (step_m3_q == 2'd2) ? 2'd0 : step_m3_q + 2'd1;
						step_scan_q <= (step_scan_q == SW'(2 * PIXEL_COUNT - 1)) ?
						               '0 : step_scan_q + SW'(1);
					end
				end
			end
			if (move_s1) begin
				valid_s1 <= accept && fire;
			end
			if (move_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && accept && fire) begin
			mode_s1   <= pattern_mode;
			bright_s1 <= base_brightness;
			step_s1   <= step_q[7:0];
			off_s1    <= step_m3_q;
			lit_s1    <= LIT_W'(scan_pos);
			phase_s1  <= phase_new;
		end
		if (move_s2 && valid_s1) begin
			mode_s2   <= mode_s1;
			bright_s2 <= bright_s1;
			step_s2   <= step_s1;
			off_s2    <= off_s1;
			lit_s2    <= lit_s1;
			bidx_s2   <= bprod[31:24];
		end
	end

	assign push_valid          = valid_s2;
	assign push_data.mode      = mode_s2;
	assign push_data.level     = (mode_s2 == MODE_BREATHE) ? BREATHE_LUT[bidx_s2] : bright_s2;
	assign push_data.step      = step_s2;
	assign push_data.chase_off = off_s2;
	assign push_data.lit       = lit_s2;

endmodule

FILE: sv/lsp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern engine frame queue
// Short register queue of frame requests between the front end and the
// pixel generator.
// ----------------------------------------------------------------------------
module lsp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  lsp_pkg::frame_t push_data,
	output logic          pop_valid,
	input  logic          pop_ready,
	output lsp_pkg::frame_t pop_data
);
	import lsp_pkg::*;

	localparam int DEPTH = 4;
	localparam int AW = $clog2(DEPTH);

	frame_t        slots_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          push_fire;
	logic          pop_fire;

	assign push_ready = (count_q != (AW + 1)'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_data   = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= wr_ptr_q + AW'(1);
			end
			if (pop_fire) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + (AW + 1)'(1);
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - (AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

FILE: sv/lsp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED strip pattern engine pixel generator
// Walks one frame request pixel by pixel into a registered output, owning
// the random generator for twinkle and sparkle frames.
// ----------------------------------------------------------------------------
module lsp_back #(
	parameter int PIXEL_COUNT = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          pop_valid,
	output logic          pop_ready,
	input  lsp_pkg::frame_t pop_data,
	input  logic [7:0]    base_red,
	input  logic [7:0]    base_green,
	input  logic [7:0]    base_blue,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [3:0]    pixel_index,
	output logic [7:0]    red,
	output logic [7:0]    green,
	output logic [7:0]    blue,
	output logic [7:0]    level,
	output logic          frame_end
);
	import lsp_pkg::*;

	localparam int IW      = $clog2(PIXEL_COUNT);
	localparam int WQ_STEP = 256 / PIXEL_COUNT;
	localparam int WR_STEP = 256 % PIXEL_COUNT;
	localparam int RW2     = (WR_STEP * 256) % PIXEL_COUNT;
	localparam int RW3     = (RW2 * 256) % PIXEL_COUNT;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MOD  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	typedef logic [LIT_W-1:0] res_lut_t [0:255];

	function automatic logic [31:0] lfsr_next(input logic [31:0] x);
		return (x >> 1) ^ (x[0] ? LFSR_TAPS : 32'd0);
	endfunction

	// A draw ends in 9 (decimal) when it is odd and is 4 modulo 5; nibbles
	// fold because 16 is 1 modulo 5.
	function automatic logic twinkle_hit(input logic [31:0] x);
		logic [6:0] s;
		logic [4:0] f;
		int k;
		s = '0;
		for (k = 0; k < 8; k++) begin
			s = s + 7'(x[4 * k +: 4]);
		end
		f = 5'(s[6:4]) + 5'(s[3:0]);
		if (f >= 5'd20) f = f - 5'd20;
		if (f >= 5'd10) f = f - 5'd10;
		if (f >= 5'd5) f = f - 5'd5;
		return x[0] && (f == 5'd4);
	endfunction

	// Entry b holds (b * weight) modulo PIXEL_COUNT, where weight is the
	// residue of the byte's place value.
	function automatic res_lut_t build_res_lut(input int weight);
		res_lut_t t;
		int acc;
		int b;
		acc = 0;
		for (b = 0; b < 256; b++) begin
			t[b] = LIT_W'(acc);
			acc = acc + weight;
			if (acc >= PIXEL_COUNT) begin
				acc = acc - PIXEL_COUNT;
			end
		end
		return t;
	endfunction

	localparam res_lut_t RES_LUT0 = build_res_lut(1);
	localparam res_lut_t RES_LUT1 = build_res_lut(WR_STEP);
	localparam res_lut_t RES_LUT2 = build_res_lut(RW2);
	localparam res_lut_t RES_LUT3 = build_res_lut(RW3);

	logic [1:0]       state_q;
	logic             cnt_q;
	logic [31:0]      lfsr_q;
	logic             out_valid_q;

	logic [2:0]       mode_q;
	logic [7:0]       level_q;
	logic [7:0]       step_q;
	logic [1:0]       off_q;
	logic [LIT_W-1:0] lit_q;
	logic [IW-1:0]    pix_q;
	logic [7:0]       wq_q;
	logic [IW-1:0]    wr_q;
	logic [1:0]       m3_q;
	logic [31:0]      word_q;
	logic [7:0]       rsum_q;

	logic [3:0]       pixel_index_q;
	logic [7:0]       red_q;
	logic [7:0]       green_q;
	logic [7:0]       blue_q;
	logic [7:0]       level_o_q;
	logic             frame_end_q;

	logic             emit;
	logic             last;
	logic             ld;
	logic [31:0]      tw_draw;
	logic [31:0]      lfsr_cur;
	logic [31:0]      spark_draw;
	logic [7:0]       rsum;
	logic [LIT_W-1:0] pix_ext;
	logic [IW:0]      wr_sum;
	logic             wr_wrap;
	logic [7:0]       wheel_p;
	logic [7:0]       wheel_q;
	logic [7:0]       seg_q;
	logic [9:0]       seg3;
	logic [7:0]       px_r;
	logic [7:0]       px_g;
	logic [7:0]       px_b;

	assign emit      = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign last      = (pix_q == IW'(PIXEL_COUNT - 1));
	assign pop_ready = (state_q == ST_IDLE) || (emit && last);
	assign ld        = pop_valid && pop_ready;

	assign tw_draw    = lfsr_next(lfsr_q);
	assign lfsr_cur   = (emit && (mode_q == MODE_TWINKLE)) ? tw_draw : lfsr_q;
	assign spark_draw = lfsr_next(lfsr_cur);
	assign rsum       = 8'(RES_LUT3[word_q[31:24]]) + 8'(RES_LUT2[word_q[23:16]]) +
	                    8'(RES_LUT1[word_q[15:8]]) + 8'(RES_LUT0[word_q[7:0]]);

	assign pix_ext = LIT_W'(pix_q);
	assign wr_sum  = (IW + 1)'(wr_q) + (IW + 1)'(WR_STEP);
	assign wr_wrap = (wr_sum >= (IW + 1)'(PIXEL_COUNT));

	assign wheel_p = wq_q + step_q;
	assign wheel_q = 8'd255 - wheel_p;

	always_comb begin
		if (wheel_q < 8'd85) begin
			seg_q = wheel_q;
		end else if (wheel_q < 8'd170) begin
			seg_q = wheel_q - 8'd85;
		end else begin
			seg_q = wheel_q - 8'd170;
		end
		seg3 = {1'b0, seg_q, 1'b0} + {2'b00, seg_q};
		px_r = 8'd0;
		px_g = 8'd0;
		px_b = 8'd0;
		case (mode_q)
			MODE_RAINBOW: begin
				if (wheel_q < 8'd85) begin
					px_r = 8'd255 - seg3[7:0];
					px_b = seg3[7:0];
				end else if (wheel_q < 8'd170) begin
					px_g = seg3[7:0];
					px_b = 8'd255 - seg3[7:0];
				end else begin
					px_r = seg3[7:0];
					px_g = 8'd255 - seg3[7:0];
				end
			end
			MODE_BREATHE: begin
				px_r = base_red;
				px_g = base_green;
				px_b = base_blue;
			end
			MODE_CHASE: begin
				if ((pix_ext >= LIT_W'(off_q)) && (m3_q == off_q)) begin
					px_r = base_red;
					px_g = base_green;
					px_b = base_blue;
				end
			end
			MODE_SCANNER: begin
				if (pix_ext == lit_q) begin
					px_r = base_red;
					px_g = base_green;
					px_b = base_blue;
				end
			end
			MODE_TWINKLE: begin
				if (twinkle_hit(tw_draw)) begin
					px_r = base_red;
					px_g = base_green;
					px_b = base_blue;
				end
			end
			default: begin
				if (pix_ext == lit_q) begin
					px_r = 8'd255;
					px_g = 8'd255;
					px_b = 8'd255;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 1'b0;
			lfsr_q      <= LFSR_SEED;
			out_valid_q <= 1'b0;
		end else begin
			if (ld) begin
				state_q <= (pop_data.mode == MODE_SPARKLE) ? ST_MOD : ST_RUN;
			end else if (emit && last) begin
				state_q <= ST_IDLE;
			end else if ((state_q == ST_MOD) && (cnt_q == 1'b1)) begin
				state_q <= ST_RUN;
			end
			if (ld) begin
				cnt_q <= 1'b0;
			end else if (state_q == ST_MOD) begin
				cnt_q <= cnt_q + 1'b1;
			end
			lfsr_q <= (ld && (pop_data.mode == MODE_SPARKLE)) ? spark_draw : lfsr_cur;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			mode_q  <= pop_data.mode;
			level_q <= pop_data.level;
			step_q  <= pop_data.step;
			off_q   <= pop_data.chase_off;
			lit_q   <= pop_data.lit;
			pix_q   <= '0;
			wq_q    <= '0;
			wr_q    <= '0;
			m3_q    <= '0;
			word_q  <= spark_draw;
		end else if (state_q == ST_MOD) begin
			rsum_q <= rsum;
			if (cnt_q == 1'b1) begin
				lit_q <= RES_LUT0[rsum_q];
			end
		end else if (emit) begin
			pix_q <= pix_q + IW'(1);
			wq_q  <= wq_q + 8'(WQ_STEP) + 8'(wr_wrap);
			wr_q  <= wr_wrap ? IW'(wr_sum - (IW + 1)'(PIXEL_COUNT)) : IW'(wr_sum);
			m3_q  <= (m3_q == 2'd2) ? 2'd0 : m3_q + 2'd1;
		end
		if (emit) begin
			pixel_index_q <= pix_ext[3:0];
			red_q         <= px_r;
			green_q       <= px_g;
			blue_q        <= px_b;
			level_o_q     <= level_q;
			frame_end_q   <= last;
		end
	end

	assign out_valid   = out_valid_q;
	assign pixel_index = pixel_index_q;
	assign red         = red_q;
	assign green       = green_q;
	assign blue        = blue_q;
	assign level       = level_o_q;
	assign frame_end   = frame_end_q;

endmodule

FILE: sv/led_strip_pattern_engine.sv
`timescale 1ns / 1ps
// Path: a time request that starts a frame passes the front end's s1 and s2 registers and the
// frame queue before its first pixel; a sparkle frame first spends ST_MOD reducing its random draw.
// Throughput: one time request per cycle while the front end is not stalled; each frame holds
// the pixel generator until its last pixel, and a four-entry frame queue absorbs bursts.
// Reset (arst_n low, asynchronous) clears time, step and queue, seeds the random generator
// and loads the register defaults.
// ----------------------------------------------------------------------------
// LED strip pattern engine
// Frame scheduler, frame queue and pixel generator for an addressable strip.
// ----------------------------------------------------------------------------
module led_strip_pattern_engine #(
	parameter int PIXEL_COUNT = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] ms_elapsed,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [3:0] pixel_index,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue,
	output logic [7:0] level,
	output logic       frame_end,
	input  logic       cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_wdata
);
	import lsp_pkg::*;

	logic [2:0] pattern_mode_q;
	logic [7:0] base_red_q;
	logic [7:0] base_green_q;
	logic [7:0] base_blue_q;
	logic [7:0] base_brightness_q;

	logic   push_valid;
	logic   push_ready;
	frame_t push_data;
	logic   pop_valid;
	logic   pop_ready;
	frame_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_mode_q    <= MODE_SOLID;
			base_red_q        <= 8'd0;
			base_green_q      <= 8'd255;
			base_blue_q       <= 8'd0;
			base_brightness_q <= 8'd80;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:       pattern_mode_q    <= cfg_wdata[2:0];
				REG_RED:        base_red_q        <= cfg_wdata;
				REG_GREEN:      base_green_q      <= cfg_wdata;
				REG_BLUE:       base_blue_q       <= cfg_wdata;
				REG_BRIGHTNESS: base_brightness_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	lsp_front #(
		.PIXEL_COUNT(PIXEL_COUNT)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.ms_elapsed     (ms_elapsed),
		.pattern_mode   (pattern_mode_q),
		.base_brightness(base_brightness_q),
		.push_valid     (push_valid),
		.push_ready     (push_ready),
		.push_data      (push_data)
	);

	lsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	lsp_back #(
		.PIXEL_COUNT(PIXEL_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.base_red   (base_red_q),
		.base_green (base_green_q),
		.base_blue  (base_blue_q),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_index(pixel_index),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.level      (level),
		.frame_end  (frame_end)
	);

endmodule

FILE: sv/lsp_checker.sv
`timescale 1ns / 1ps
`include "led_strip_pattern_engine_macros.svh"
// ----------------------------------------------------------------------------
// LED strip pattern engine port checker
// Watches output pixel order, frame starts, per-frame level and stalled-pixel holds.
// ----------------------------------------------------------------------------
module lsp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [3:0] pixel_index,
	input logic [7:0] level,
	input logic       frame_end
);

	`LSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pixel_index) && $stable(level) && $stable(frame_end))
	`LSP_ASSERT_NEXT(a_pixel_order, out_valid && out_ready && !frame_end, out_valid && (pixel_index == 4'($past(pixel_index) + 4'd1)))
	`LSP_ASSERT_NEXT(a_frame_level, out_valid && out_ready && !frame_end, level == $past(level))
	`LSP_ASSERT_NEXT(a_frame_start, out_valid && out_ready && frame_end, !out_valid || (pixel_index == 4'd0))

endmodule

bind led_strip_pattern_engine lsp_checker u_lsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.pixel_index(pixel_index),
	.level      (level),
	.frame_end  (frame_end)
);
